// File: hw/rtl/mpfr_pkg.sv
// Shared types and constants for the mask-based feature record pruner.
// Used by mpfr_ctrl, mpfr_dp and mask_prune_feature_records.
`default_nettype none

package mpfr_pkg;

	localparam int DEF_MAX_RECORDS     = 256;
	localparam int DEF_MAX_MASK_WIDTH  = 128;
	localparam int DEF_MAX_MASK_HEIGHT = 128;

	// Rounding of an 8.8 coordinate to the nearest pixel.
	localparam logic [15:0] ROUND_BIAS = 16'h0080;
	localparam int          FRAC_BITS  = 8;

	typedef enum logic [2:0] {
		OP_MASK_WR = 3'd0,
		OP_APPEND  = 3'd1,
		OP_PRUNE   = 3'd2,
		OP_READ    = 3'd3,
		OP_CLEAR   = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_MASK = 2'd1,
		STAT_OVERFLOW = 2'd2,
		STAT_BAD_SLOT = 2'd3
	} status_t;

	typedef enum logic {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_CALC,
		ST_MREAD,
		ST_DECIDE,
		ST_MOVE,
		ST_SLOT,
		ST_POST
	} state_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  idx;
	} rec_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    mask_wr;
		logic    append;
		logic    clear;
		logic    res_err;
		status_t code;
		logic    prune_start;
		logic    walk_rd;
		logic    calc;
		logic    mask_rd;
		logic    drop;
		logic    keep;
		logic    move_wr;
		logic    prune_done;
		logic    slot_rd;
		logic    slot_ld;
		logic    out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mask_bad;
		logic ovf;
		logic slot_ok;
		logic walk_more;
		logic drop_hit;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/mask_prune_feature_records.sv
// Feature record pruner with a one-bit keep mask: top level.
// The input channel (in_valid/in_stall) takes one request per accept: a mask
// pixel write, a record append, a prune, a slot read or a list clear. Only
// prune and slot read produce a response on the output channel
// (out_valid/out_stall); the other requests complete in the accepting cycle.
// Mask writes, appends and clears are taken one per cycle while the input is
// open. A slot read holds off the input until its reply is loaded. A prune
// holds it off until its walk is done and its reply is loaded; every visited
// record takes one record memory read, a rounding and address multiply, and
// one mask memory read, and a drop copies the last record into the freed slot.
// A rejected prune (bad mask size or overflowed list) skips the walk.
// The response becomes valid at the same edge that reopens the input.
// The response sits in an output register; while the receiver stalls it holds,
// and the block keeps accepting requests that produce no response. A request
// that needs the output waits in its final step until the register frees.
// Reset clears list count, overflow flag, size registers and output valid; mask
// and record memories hold nothing defined until written. The user must write
// size registers via cfg_we/cfg_index/cfg_data only while idle (unenforced).
`default_nettype none

module mask_prune_feature_records #(
	parameter int MAX_RECORDS     = mpfr_pkg::DEF_MAX_RECORDS,
	parameter int MAX_MASK_WIDTH  = mpfr_pkg::DEF_MAX_MASK_WIDTH,
	parameter int MAX_MASK_HEIGHT = mpfr_pkg::DEF_MAX_MASK_HEIGHT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  opcode,
	input  wire logic [13:0] mask_index,
	input  wire logic [7:0]  mask_value,
	input  wire logic [15:0] x_raw,
	input  wire logic [15:0] y_raw,
	input  wire logic [7:0]  slot,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [8:0]       kept_count,
	output logic [7:0]       original_index,
	output logic [15:0]      slot_x_raw,
	output logic [15:0]      slot_y_raw
);
	import mpfr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mpfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	mpfr_dp #(
		.MAX_RECORDS     (MAX_RECORDS),
		.MAX_MASK_WIDTH  (MAX_MASK_WIDTH),
		.MAX_MASK_HEIGHT (MAX_MASK_HEIGHT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mask_index     (mask_index),
		.mask_value     (mask_value),
		.x_raw          (x_raw),
		.y_raw          (y_raw),
		.slot           (slot),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.kept_count     (kept_count),
		.original_index (original_index),
		.slot_x_raw     (slot_x_raw),
		.slot_y_raw     (slot_y_raw)
	);

	// A dropped record is always followed by the copy into its slot.
	a_drop_then_move: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |=> cmd.move_wr)
		else $error("drop not followed by record move");

	// Every record read during a walk is evaluated on the next cycle.
	a_read_then_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_rd |=> cmd.calc)
		else $error("record read not followed by evaluation");

	// The walk never runs while the input side is open.
	a_walk_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !(cmd.walk_rd || cmd.drop || cmd.move_wr || cmd.calc))
		else $error("walk command while input is open");

	// The output register is only loaded when it is free.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("output overwritten while stalled");

endmodule

`default_nettype wire

// File: hw/rtl/mpfr_ctrl.sv
// Controller state machine for the feature record pruner.
// Depends on mpfr_pkg; drives the command struct consumed by mpfr_dp.
`default_nettype none

module mpfr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [2:0]    opcode,
	input  mpfr_pkg::sts_t     sts,
	output mpfr_pkg::cmd_t     cmd,
	output logic               in_stall
);
	import mpfr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (opcode_t'(opcode))
						OP_PRUNE: begin
							if (sts.mask_bad || sts.ovf) begin
								state_d = ST_POST;
							end else begin
								state_d = ST_WALK;
							end
						end
						OP_READ: begin
							state_d = sts.slot_ok ? ST_SLOT : ST_POST;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_WALK:   state_d = sts.walk_more ? ST_CALC : ST_POST;
			ST_CALC:   state_d = ST_MREAD;
			ST_MREAD:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = sts.drop_hit ? ST_MOVE : ST_WALK;
			ST_MOVE:   state_d = ST_WALK;
			ST_SLOT:   state_d = ST_POST;
			ST_POST:   state_d = sts.out_free ? ST_IDLE : ST_POST;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.code = STAT_OK;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (opcode_t'(opcode))
						OP_MASK_WR: cmd.mask_wr = 1'b1;
						OP_APPEND:  cmd.append  = 1'b1;
						OP_CLEAR:   cmd.clear   = 1'b1;
						OP_PRUNE: begin
							// The mask size check takes precedence over overflow.
							if (sts.mask_bad) begin
								cmd.res_err = 1'b1;
								cmd.code    = STAT_BAD_MASK;
							end else if (sts.ovf) begin
								cmd.res_err = 1'b1;
								cmd.code    = STAT_OVERFLOW;
							end else begin
								cmd.prune_start = 1'b1;
							end
						end
						OP_READ: begin
							if (sts.slot_ok) begin
								cmd.slot_rd = 1'b1;
							end else begin
								cmd.res_err = 1'b1;
								cmd.code    = STAT_BAD_SLOT;
							end
						end
						default: cmd = cmd;
					endcase
				end
			end
			ST_WALK: begin
				if (sts.walk_more) begin
					cmd.walk_rd = 1'b1;
				end else begin
					cmd.prune_done = 1'b1;
				end
			end
			ST_CALC:  cmd.calc    = 1'b1;
			ST_MREAD: cmd.mask_rd = 1'b1;
			ST_DECIDE: begin
				if (sts.drop_hit) begin
					cmd.drop = 1'b1;
				end else begin
					cmd.keep = 1'b1;
				end
			end
			ST_MOVE: cmd.move_wr  = 1'b1;
			ST_SLOT: cmd.slot_ld  = 1'b1;
			ST_POST: cmd.out_load = sts.out_free;
			default: cmd = cmd;
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/mpfr_dp.sv
// Datapath of the feature record pruner: mask and record memories, list
// counters, coordinate rounding, address multiply and the output register.
// Depends on mpfr_pkg; sequenced by mpfr_ctrl.
`default_nettype none

module mpfr_dp #(
	parameter int MAX_RECORDS     = mpfr_pkg::DEF_MAX_RECORDS,
	parameter int MAX_MASK_WIDTH  = mpfr_pkg::DEF_MAX_MASK_WIDTH,
	parameter int MAX_MASK_HEIGHT = mpfr_pkg::DEF_MAX_MASK_HEIGHT
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  mpfr_pkg::cmd_t      cmd,
	output mpfr_pkg::sts_t      sts,
	input  wire logic           cfg_we,
	input  wire logic           cfg_index,
	input  wire logic [7:0]     cfg_data,
	input  wire logic [13:0]    mask_index,
	input  wire logic [7:0]     mask_value,
	input  wire logic [15:0]    x_raw,
	input  wire logic [15:0]    y_raw,
	input  wire logic [7:0]     slot,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [1:0]          status,
	output logic [8:0]          kept_count,
	output logic [7:0]          original_index,
	output logic [15:0]         slot_x_raw,
	output logic [15:0]         slot_y_raw
);
	import mpfr_pkg::*;

	localparam int MASK_DEPTH = MAX_MASK_WIDTH * MAX_MASK_HEIGHT;
	localparam int MA_W       = $clog2(MASK_DEPTH);
	localparam int CW         = $clog2(MAX_RECORDS + 1);
	localparam int RA_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

	logic            mask_mem [MASK_DEPTH];
	rec_t            rec_mem  [MAX_RECORDS];

	logic [7:0]      mask_width_q;
	logic [7:0]      mask_height_q;
	logic [CW-1:0]   count_q;
	logic            ovf_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   n_q;
	rec_t            rd_data_q;
	logic            mask_bit_q;

	logic [15:0]     addr_s1;
	logic            inside_s1;
	logic            hit_s2;

	status_t         res_status_q;
	logic [CW-1:0]   res_count_q;
	rec_t            res_rec_q;

	logic            out_valid_q;
	status_t         out_status_q;
	logic [CW-1:0]   out_count_q;
	rec_t            out_rec_q;

	logic [8:0]      rx;
	logic [8:0]      ry;
	logic            full;
	logic            rec_we;
	logic [RA_W-1:0] rec_waddr;
	rec_t            rec_wdata;
	logic            rec_re;
	logic [RA_W-1:0] rec_raddr;
	logic [CW-1:0]   n_dec;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_width_q  <= '0;
			mask_height_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_WIDTH:  mask_width_q  <= cfg_data;
				CFG_HEIGHT: mask_height_q <= cfg_data;
				default:    mask_width_q  <= mask_width_q;
			endcase
		end
	end

	assign full  = (count_q >= CW'(MAX_RECORDS));
	assign n_dec = n_q - CW'(1);

	assign sts.mask_bad  = (mask_width_q == '0) || (mask_height_q == '0) ||
	                       (32'(mask_width_q) > MAX_MASK_WIDTH) ||
	                       (32'(mask_height_q) > MAX_MASK_HEIGHT);
	assign sts.ovf       = ovf_q;
	assign sts.slot_ok   = (32'(slot) < 32'(count_q)) && (32'(slot) < MAX_RECORDS);
	assign sts.walk_more = (i_q < n_q);
	assign sts.drop_hit  = hit_s2 && !mask_bit_q;
	assign sts.out_free  = !out_valid_q || !out_stall;

	// List bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.append) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end else if (cmd.prune_done) begin
				count_q <= n_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prune_start) begin
			i_q <= '0;
			n_q <= count_q;
		end else if (cmd.keep) begin
			i_q <= i_q + CW'(1);
		end else if (cmd.drop) begin
			n_q <= n_dec;
		end
	end

	// Record memory: one write port and one registered read port.
	assign rec_we    = (cmd.append && !full) || cmd.move_wr;
	assign rec_waddr = cmd.append ? RA_W'(count_q) : RA_W'(i_q);
	assign rec_wdata = cmd.append ? rec_t'{x: x_raw, y: y_raw, idx: 8'(count_q)} : rd_data_q;
	assign rec_re    = cmd.walk_rd || cmd.drop || cmd.slot_rd;

	always_comb begin
		priority if (cmd.walk_rd) begin
			rec_raddr = RA_W'(i_q);
		end else if (cmd.drop) begin
			rec_raddr = RA_W'(n_dec);
		end else begin
			rec_raddr = RA_W'(slot);
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		if (rec_re) begin
			rd_data_q <= rec_mem[rec_raddr];
		end
	end

	// Keep mask memory.
	always_ff @(posedge clk) begin
		if (cmd.mask_wr && (32'(mask_index) < MASK_DEPTH)) begin
			mask_mem[MA_W'(mask_index)] <= |mask_value;
		end
		if (cmd.mask_rd) begin
			mask_bit_q <= mask_mem[MA_W'(addr_s1)];
		end
	end

	// Round to the nearest pixel; a rounded value of 256 is simply outside.
	assign rx = 9'(({1'b0, rd_data_q.x} + {1'b0, ROUND_BIAS}) >> FRAC_BITS);
	assign ry = 9'(({1'b0, rd_data_q.y} + {1'b0, ROUND_BIAS}) >> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			inside_s1 <= (rx < {1'b0, mask_width_q}) && (ry < {1'b0, mask_height_q});
			addr_s1   <= 16'(ry[7:0]) * 16'(mask_width_q) + 16'(rx[7:0]);
		end
		if (cmd.mask_rd) begin
			hit_s2 <= inside_s1 && (32'(addr_s1) < MASK_DEPTH);
		end
	end

	// Result staging.
	always_ff @(posedge clk) begin
		if (cmd.res_err) begin
			res_status_q <= cmd.code;
			res_count_q  <= count_q;
			res_rec_q    <= '0;
		end else if (cmd.prune_done) begin
			res_status_q <= STAT_OK;
			res_count_q  <= n_q;
			res_rec_q    <= '0;
		end else if (cmd.slot_ld) begin
			res_status_q <= STAT_OK;
			res_count_q  <= count_q;
			res_rec_q    <= rd_data_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_count_q  <= res_count_q;
			out_rec_q    <= res_rec_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign kept_count     = 9'(out_count_q);
	assign original_index = out_rec_q.idx;
	assign slot_x_raw     = out_rec_q.x;
	assign slot_y_raw     = out_rec_q.y;

endmodule

`default_nettype wire

// File: verif/prune_reply_checker.sv
// Reply checker for mask_prune_feature_records: watches the request, reply and
// register write ports, keeps its own mask and record list, and checks replies.
// Depends on mpfr_pkg for the opcode, status, register index and record types.
module prune_reply_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [2:0]  opcode,
	input  wire logic [13:0] mask_index,
	input  wire logic [7:0]  mask_value,
	input  wire logic [15:0] x_raw,
	input  wire logic [15:0] y_raw,
	input  wire logic [7:0]  slot,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  status,
	input  wire logic [8:0]  kept_count,
	input  wire logic [7:0]  original_index,
	input  wire logic [15:0] slot_x_raw,
	input  wire logic [15:0] slot_y_raw,
	output int               mismatches,
	output int               replies_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import mpfr_pkg::*;

	localparam int MASK_CELLS = DEF_MAX_MASK_WIDTH * DEF_MAX_MASK_HEIGHT;

	typedef struct packed {
		status_t     status;
		logic [8:0]  kept;
		logic [7:0]  orig;
		logic [15:0] x;
		logic [15:0] y;
	} reply_t;

	bit          keep_px [MASK_CELLS];
	rec_t        list_rec [DEF_MAX_RECORDS];
	int unsigned list_len;
	bit          list_overflowed;
	logic [7:0]  width_px;
	logic [7:0]  height_px;
	reply_t      replies_due [$];

	function automatic int unsigned nearest_pixel(logic [15:0] v);
		return ({1'b0, v} + {1'b0, ROUND_BIAS}) >> FRAC_BITS;
	endfunction

	// Walks the list; a dropped record takes the last one's place and that
	// record is examined again at the same position.
	function automatic status_t prune_list();
		int unsigned i;
		int unsigned n;
		int unsigned px;
		int unsigned py;
		bit          drop;
		if (width_px == 0 || height_px == 0 || width_px > DEF_MAX_MASK_WIDTH ||
				height_px > DEF_MAX_MASK_HEIGHT)
			return STAT_BAD_MASK;
		if (list_overflowed)
			return STAT_OVERFLOW;
		i = 0;
		n = list_len;
		while (i < n) begin
			px = nearest_pixel(list_rec[i].x);
			py = nearest_pixel(list_rec[i].y);
			drop = px < width_px && py < height_px && !keep_px[py * width_px + px];
			if (drop) begin
				n--;
				list_rec[i] = list_rec[n];
			end else begin
				i++;
			end
		end
		list_len = n;
		return STAT_OK;
	endfunction

	function automatic reply_t read_slot(logic [7:0] s);
		reply_t r;
		r = '0;
		r.kept = 9'(list_len);
		if (s < list_len) begin
			r.status = STAT_OK;
			r.orig = list_rec[s].idx;
			r.x = list_rec[s].x;
			r.y = list_rec[s].y;
		end else begin
			r.status = STAT_BAD_SLOT;
		end
		return r;
	endfunction

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t due;
		if (!arst_n) begin
			list_len = 0;
			list_overflowed = 1'b0;
			width_px = '0;
			height_px = '0;
			replies_due.delete();
			mismatches = 0;
			replies_owed <= 0;
		end else begin
			// Replies belong to earlier requests, so they are checked first.
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("reply with none outstanding: status %0d, kept_count %0d",
						status, kept_count);
					mismatches++;
				end else begin
					due = replies_due.pop_front();
					compare_field("status", due.status, status);
					compare_field("kept_count", due.kept, kept_count);
					compare_field("original_index", due.orig, original_index);
					compare_field("slot_x_raw", due.x, slot_x_raw);
					compare_field("slot_y_raw", due.y, slot_y_raw);
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_WIDTH)
					width_px = cfg_data;
				else
					height_px = cfg_data;
			end
			if (in_valid && !in_stall) begin
				case (opcode)
				OP_MASK_WR: keep_px[mask_index] = (mask_value != 8'd0);
				OP_APPEND: begin
					if (list_len < DEF_MAX_RECORDS) begin
						list_rec[list_len] = '{x: x_raw, y: y_raw, idx: 8'(list_len)};
						list_len++;
					end else begin
						list_overflowed = 1'b1;
					end
				end
				OP_PRUNE: begin
					due = '0;
					due.status = prune_list();
					due.kept = 9'(list_len);
					replies_due.push_back(due);
				end
				OP_READ: replies_due.push_back(read_slot(slot));
				OP_CLEAR: begin
					list_len = 0;
					list_overflowed = 1'b0;
				end
				default: ;
				endcase
			end
			replies_owed <= replies_due.size();
		end
	end

endmodule

// File: verif/mask_prune_feature_records_test.sv
// Testbench top for mask_prune_feature_records: clock, reset, mask size
// writes, requests and reply stalls, and the verdict.
// Depends on mpfr_pkg, the block itself and prune_reply_checker.
module mask_prune_feature_records_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mpfr_pkg::*;

	localparam int QUIET_LIMIT = 10000;
	localparam int RANDOM_REQUESTS = 1800;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [2:0]  op;
		logic [13:0] midx;
		logic [7:0]  mval;
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  s;
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_WIDTH;
	logic [7:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = '0;
	logic [13:0] mask_index = '0;
	logic [7:0]  mask_value = '0;
	logic [15:0] x_raw = '0;
	logic [15:0] y_raw = '0;
	logic [7:0]  slot = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [8:0]  kept_count;
	logic [7:0]  original_index;
	logic [15:0] slot_x_raw;
	logic [15:0] slot_y_raw;
	int          mismatches;
	int          replies_owed;

	bit          sender_gaps = 1'b0;
	bit          receiver_gaps = 1'b0;
	int          requests_sent = 0;
	int          quiet_cycles = 0;
	logic [7:0]  cur_w = '0;
	logic [7:0]  cur_h = '0;
	bit          pixel_set [DEF_MAX_MASK_WIDTH * DEF_MAX_MASK_HEIGHT];

	mask_prune_feature_records u_dut (.*);
	prune_reply_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("mask_prune_feature_records_test: done, errors");
			$finish;
		end
	end

	function automatic bit size_ok();
		return cur_w != 0 && cur_h != 0 && cur_w <= DEF_MAX_MASK_WIDTH &&
			cur_h <= DEF_MAX_MASK_HEIGHT;
	endfunction

	function automatic request_t blank_request(logic [2:0] op);
		request_t rq;
		rq.op = op;
		rq.midx = 14'($urandom);
		rq.mval = 8'($urandom);
		rq.x = 16'($urandom);
		rq.y = 16'($urandom);
		rq.s = 8'($urandom);
		return rq;
	endfunction

	function automatic logic [7:0] draw_pixel();
		return $urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : 8'd0;
	endfunction

	// A raw 8.8 word that rounds to pixel p, with a random fraction.
	function automatic logic [15:0] fixed_near(int p);
		int v;
		v = p * 256 + int'($urandom_range(0, 255)) - 128;
		if (v < 0)
			v = 0;
		return 16'(v);
	endfunction

	function automatic logic [15:0] draw_coord(int lim);
		int k;
		k = $urandom_range(0, 9);
		if (lim == 0 || k == 9)
			return 16'($urandom);
		if (k == 8)
			return 16'($urandom_range(16'hFF80, 16'hFFFF));
		if (k == 7)
			return fixed_near(lim);
		return fixed_near($urandom_range(0, lim - 1));
	endfunction

	task automatic send_request(input request_t rq);
		int gap;
		gap = sender_gaps ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode <= rq.op;
		mask_index <= rq.midx;
		mask_value <= rq.mval;
		x_raw <= rq.x;
		y_raw <= rq.y;
		slot <= rq.s;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (rq.op <= OP_CLEAR)
			requests_sent++;
	endtask

	task automatic mask_write(input int a, input logic [7:0] v);
		request_t rq;
		rq = blank_request(OP_MASK_WR);
		rq.midx = 14'(a);
		rq.mval = v;
		send_request(rq);
		pixel_set[a] = 1'b1;
	endtask

	// A record whose point lands inside the mask gets its pixel written first,
	// so that a prune never looks at a pixel that holds nothing yet.
	task automatic append_point(input logic [15:0] x, input logic [15:0] y);
		request_t rq;
		int px;
		int py;
		px = (int'(x) + 128) >> 8;
		py = (int'(y) + 128) >> 8;
		if (size_ok() && px < cur_w && py < cur_h && !pixel_set[py * cur_w + px])
			mask_write(py * cur_w + px, draw_pixel());
		rq = blank_request(OP_APPEND);
		rq.x = x;
		rq.y = y;
		send_request(rq);
	endtask

	// Waits until every reply is back and the block has gone quiet, then writes the new width and height.
	task automatic resize_mask(input logic [7:0] w, input logic [7:0] h);
		in_valid <= 1'b0;
		while (replies_owed != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_w = w;
		cur_h = h;
	endtask

	// Reply side; twice it holds off for a long stretch so the block backs up.
	initial begin
		int hold;
		int taken;
		taken = 0;
		@(negedge clk);
		forever begin
			if (taken == 60 || taken == 300)
				hold = 400;
			else
				hold = receiver_gaps ? $urandom_range(0, 16) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		request_t rq;
		int phase_no;
		int steps;
		int r;
		logic [7:0] w;
		logic [7:0] h;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: a 4x3 mask where the first record and the one moved into
		// its place are both dropped, plus reads, unused opcodes and bad sizes.
		resize_mask(8'd4, 8'd3);
		send_request(blank_request(OP_CLEAR));
		mask_write(0, 8'h00);
		mask_write(1, 8'hFF);
		mask_write(2, 8'h01);
		mask_write(3, 8'h00);
		mask_write(16383, 8'h80);
		append_point(16'h0000, 16'h0000);
		append_point(16'h0080, 16'h007F);
		append_point(16'hFFFF, 16'hFFFF);
		append_point(16'h0300, 16'h0000);
		send_request(blank_request(OP_PRUNE));
		for (int s = 0; s < 3; s++) begin
			rq = blank_request(OP_READ);
			rq.s = 8'(s);
			send_request(rq);
		end
		rq = blank_request(OP_READ);
		rq.s = 8'd255;
		send_request(rq);
		for (int op = 5; op < 8; op++)
			send_request(blank_request(3'(op)));
		send_request(blank_request(OP_PRUNE));
		resize_mask(8'd0, 8'd3);
		send_request(blank_request(OP_PRUNE));
		resize_mask(8'd255, 8'd128);
		send_request(blank_request(OP_PRUNE));
		resize_mask(8'd128, 8'd0);
		send_request(blank_request(OP_PRUNE));

		phase_no = 0;
		while (requests_sent < RANDOM_REQUESTS) begin
			r = $urandom_range(0, 9);
			case (r)
			0: begin w = 8'd128; h = 8'd128; end
			1: begin w = 8'd1; h = 8'd1; end
			2: begin w = 8'd1; h = 8'd128; end
			3: begin w = 8'd128; h = 8'd1; end
			4: begin
				w = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 128));
				h = (w == 0) ? 8'($urandom_range(0, 128)) : 8'd0;
			end
			5: begin
				w = 8'($urandom_range(129, 255));
				h = 8'($urandom_range(1, 255));
			end
			default: begin
				w = 8'($urandom_range(1, 128));
				h = 8'($urandom_range(1, 128));
			end
			endcase
			if (phase_no % 6 == 1) begin
				w = 8'($urandom_range(1, 128));
				h = 8'($urandom_range(1, 128));
			end
			sender_gaps = $urandom_range(0, 3) != 0;
			receiver_gaps = $urandom_range(0, 3) != 0;
			resize_mask(w, h);
			send_request(blank_request(OP_CLEAR));

			if (phase_no % 6 == 1) begin
				// Fill the list past its end, then prune and read the last slot, then clear and prune.
				repeat ($urandom_range(257, 262))
					append_point(draw_coord(cur_w), draw_coord(cur_h));
				send_request(blank_request(OP_PRUNE));
				rq = blank_request(OP_READ);
				rq.s = 8'd255;
				send_request(rq);
				send_request(blank_request(OP_CLEAR));
				send_request(blank_request(OP_PRUNE));
			end else begin
				steps = $urandom_range(30, 120);
				repeat (steps) begin
					r = $urandom_range(0, 99);
					if (r < 22) begin
						if (size_ok())
							mask_write($urandom_range(0, cur_w * cur_h - 1), draw_pixel());
						else
							mask_write($urandom_range(0, 16383), draw_pixel());
					end else if (r < 60) begin
						append_point(draw_coord(cur_w), draw_coord(cur_h));
					end else if (r < 68) begin
						send_request(blank_request(OP_PRUNE));
					end else if (r < 90) begin
						rq = blank_request(OP_READ);
						if ($urandom_range(0, 3) != 0)
							rq.s = 8'($urandom_range(0, 40));
						send_request(rq);
					end else if (r < 93) begin
						send_request(blank_request(OP_CLEAR));
					end else if (r < 97) begin
						mask_write($urandom_range(0, 16383), draw_pixel());
					end else begin
						send_request(blank_request(3'($urandom_range(5, 7))));
					end
				end
			end
			phase_no++;
		end

		in_valid <= 1'b0;
		while (replies_owed != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && replies_owed == 0)
			$display("mask_prune_feature_records_test: done, clean");
		else
			$display("mask_prune_feature_records_test: done, errors");
		$finish;
	end

endmodule
